>>> sv/fuzzy_gain_scheduled_pi_top_assert.svh
// Assertion macros shared by the fuzzy gain-scheduled PI controller RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef FUZZY_GAIN_SCHEDULED_PI_TOP_ASSERT_SVH
`define FUZZY_GAIN_SCHEDULED_PI_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FGS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define FGS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/fgs_pkg.sv
// Shared types and constants for the fuzzy gain-scheduled PI controller.
// No dependencies.
`default_nettype none
package fgs_pkg;

  localparam int ERR_W      = 16;
  localparam int SUM_W      = 32;
  localparam int KP_W       = 16;
  localparam int KI_W       = 20;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KP_SMALL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_MEDIUM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_LARGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_SMALL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_MEDIUM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_LARGE  = 3'd5;

  // Gain reset values
  localparam logic [KP_W-1:0] KP_SMALL_RST  = 16'd13107;
  localparam logic [KP_W-1:0] KP_MEDIUM_RST = 16'd32768;
  localparam logic [KP_W-1:0] KP_LARGE_RST  = 16'd52429;
  localparam logic [KI_W-1:0] KI_SMALL_RST  = 20'd50332;
  localparam logic [KI_W-1:0] KI_MEDIUM_RST = 20'd21810;
  localparam logic [KI_W-1:0] KI_LARGE_RST  = 20'd38588;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRADE,
    ST_MAC,
    ST_DIV_LOAD,
    ST_DIV,
    ST_GAIN,
    ST_MUL,
    ST_SUM
  } fsm_state_t;

  typedef enum logic [1:0] {
    CLS_SMALL,
    CLS_MEDIUM,
    CLS_LARGE
  } cls_t;

  typedef struct packed {
    logic load;
    logic grade;
    logic mac;
    cls_t mac_sel;
    logic div_load;
    logic div_step;
    logic gain_upd;
    logic mul;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> sv/fgs_in_if.sv
// Input channel: one signed error sample per transfer.
// Depends on fgs_pkg for the field width.
`default_nettype none
interface fgs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fgs_pkg::ERR_W-1:0]     error_sample;

  modport source (output valid, output error_sample, input ready);
  modport sink   (input valid, input error_sample, output ready);
endinterface
`default_nettype wire

>>> sv/fgs_out_if.sv
// Result channel: duty value and the gains in use, one transfer per sample.
// Depends on fgs_pkg for the field widths.
`default_nettype none
interface fgs_out_if;
  logic                          valid;
  logic                          ready;
  logic [fgs_pkg::DUTY_W-1:0]    pwm_duty;
  logic [fgs_pkg::KP_W-1:0]      kp_now;
  logic [fgs_pkg::KI_W-1:0]      ki_now;

  modport source (output valid, output pwm_duty, output kp_now, output ki_now, input ready);
  modport sink   (input valid, input pwm_duty, input kp_now, input ki_now, output ready);
endinterface
`default_nettype wire

>>> sv/fgs_ctrl.sv
// Sequencer for the fuzzy gain-scheduled PI controller.
// Depends on fgs_pkg and the assertion macro header.
`default_nettype none
`include "fuzzy_gain_scheduled_pi_top_assert.svh"
module fgs_ctrl #(
  parameter int DIV_STEPS = 27
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fgs_pkg::dp_sts_t  sts,
  output fgs_pkg::ctl_cmd_t      cmd
);

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST_CLS = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_LAST_DIV = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);

  fgs_pkg::fsm_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fgs_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      fgs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = fgs_pkg::ST_GRADE;
        end
      end
      fgs_pkg::ST_GRADE: begin
        cmd.grade = 1'b1;
        cnt_nxt   = '0;
        state_nxt = fgs_pkg::ST_MAC;
      end
      fgs_pkg::ST_MAC: begin
        cmd.mac     = 1'b1;
        cmd.mac_sel = fgs_pkg::cls_t'(cnt_r[1:0]);
        cnt_nxt     = cnt_r + CNT_ONE;
        if (cnt_r == CNT_LAST_CLS) begin
          cnt_nxt   = '0;
          // no grade fired: keep the old gains
          state_nxt = sts.den_zero ? fgs_pkg::ST_MUL : fgs_pkg::ST_DIV_LOAD;
        end
      end
      fgs_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = fgs_pkg::ST_DIV;
      end
      fgs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_ONE;
        if (cnt_r == CNT_LAST_DIV) begin
          cnt_nxt   = '0;
          state_nxt = fgs_pkg::ST_GAIN;
        end
      end
      fgs_pkg::ST_GAIN: begin
        cmd.gain_upd = 1'b1;
        state_nxt    = fgs_pkg::ST_MUL;
      end
      fgs_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = fgs_pkg::ST_SUM;
      end
      fgs_pkg::ST_SUM: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = fgs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fgs_pkg::ST_IDLE;
      end
    endcase
  end

  `FGS_ASSERT_NXT(a_accept_to_grade, in_valid && in_ready, state_r == fgs_pkg::ST_GRADE)
  `FGS_ASSERT_IMP(a_div_nonzero_den, cmd.div_step || cmd.div_load, !sts.den_zero)
  `FGS_ASSERT_IMP(a_load_when_free, cmd.out_load, sts.out_free)

endmodule
`default_nettype wire

>>> sv/fgs_dp.sv
// Datapath: fuzzification, gain blending with a shift-subtract divider,
// saturating accumulator, PI products and duty clamp. Depends on fgs_pkg.
`default_nettype none
`include "fuzzy_gain_scheduled_pi_top_assert.svh"
module fgs_dp #(
  parameter int BAND = 20,
  parameter int GW   = 5,
  parameter int NW   = 27
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire fgs_pkg::ctl_cmd_t                     cmd,
  output fgs_pkg::dp_sts_t                           sts,
  input  wire logic signed [fgs_pkg::ERR_W-1:0]      error_sample,
  input  wire logic                                  cfg_we,
  input  wire logic [fgs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [fgs_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output logic [fgs_pkg::DUTY_W-1:0]                 pwm_duty,
  output logic [fgs_pkg::KP_W-1:0]                   kp_now,
  output logic [fgs_pkg::KI_W-1:0]                   ki_now
);

  localparam int EW    = fgs_pkg::ERR_W;
  localparam int SW    = fgs_pkg::SUM_W;
  localparam int KPW   = fgs_pkg::KP_W;
  localparam int KIW   = fgs_pkg::KI_W;
  localparam int DW    = GW + 2;
  localparam int NKP_W = KPW + GW + 2;
  localparam int PKP_W = KPW + EW + 1;
  localparam int PKI_W = KIW + SW + 1;
  localparam int V_W   = PKI_W + 1;
  localparam int Q_W   = V_W - 24;
  localparam logic signed [EW:0] BAND_S = (EW + 1)'(BAND);
  localparam logic [GW-1:0]      BAND_G = GW'(BAND);
  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW - 1){1'b0}}};

  // Triangular grades {negative, zero, positive}
  function automatic logic [3*GW-1:0] grade3(input logic signed [EW:0] x);
    logic [GW-1:0]     n, z, p;
    logic signed [EW:0] negx;
    n    = '0;
    z    = '0;
    p    = '0;
    negx = -x;
    if (x <= -BAND_S) begin
      n = BAND_G;
    end else if (x >= BAND_S) begin
      p = BAND_G;
    end else if (!x[EW]) begin
      p = x[GW-1:0];
      z = BAND_G - x[GW-1:0];
    end else begin
      n = negx[GW-1:0];
      z = BAND_G - negx[GW-1:0];
    end
    return {n, z, p};
  endfunction

  function automatic logic [GW-1:0] gmin(input logic [GW-1:0] a, input logic [GW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [GW-1:0] gmax(input logic [GW-1:0] a, input logic [GW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // One restoring division step: returns {remainder, shifted numerator/quotient}
  function automatic logic [DW+NW-1:0] div_iter(input logic [DW-1:0] rem,
                                                input logic [NW-1:0] num,
                                                input logic [DW-1:0] dv);
    logic [DW:0] sh, df;
    sh = {rem, num[NW-1]};
    df = sh - {1'b0, dv};
    if (sh >= {1'b0, dv}) begin
      return {df[DW-1:0], num[NW-2:0], 1'b1};
    end
    return {sh[DW-1:0], num[NW-2:0], 1'b0};
  endfunction

  // Configuration registers
  logic [KPW-1:0] kps_r, kpm_r, kpl_r;
  logic [KIW-1:0] kis_r, kim_r, kil_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kps_r <= fgs_pkg::KP_SMALL_RST;
      kpm_r <= fgs_pkg::KP_MEDIUM_RST;
      kpl_r <= fgs_pkg::KP_LARGE_RST;
      kis_r <= fgs_pkg::KI_SMALL_RST;
      kim_r <= fgs_pkg::KI_MEDIUM_RST;
      kil_r <= fgs_pkg::KI_LARGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fgs_pkg::CFG_KP_SMALL:  kps_r <= cfg_wdata[KPW-1:0];
        fgs_pkg::CFG_KP_MEDIUM: kpm_r <= cfg_wdata[KPW-1:0];
        fgs_pkg::CFG_KP_LARGE:  kpl_r <= cfg_wdata[KPW-1:0];
        fgs_pkg::CFG_KI_SMALL:  kis_r <= cfg_wdata[KIW-1:0];
        fgs_pkg::CFG_KI_MEDIUM: kim_r <= cfg_wdata[KIW-1:0];
        fgs_pkg::CFG_KI_LARGE:  kil_r <= cfg_wdata[KIW-1:0];
        default: ;
      endcase
    end
  end

  // Loop state
  logic signed [EW-1:0] prev_r, e_r;
  logic signed [EW:0]   d_r;
  logic signed [SW-1:0] sum_r;
  logic [KPW-1:0]       kp_held_r;
  logic [KIW-1:0]       ki_held_r;

  // Class grades, accumulators and divider
  logic [GW-1:0]     s_r, m_r, l_r;
  logic [NKP_W-1:0]  acc_kp_r;
  logic [NW-1:0]     acc_ki_r;
  logic [NW-1:0]     nkp_r, nki_r;
  logic [DW-1:0]     rkp_r, rki_r;
  logic signed [PKP_W-1:0] pkp_r;
  logic signed [PKI_W-1:0] pki_r;

  // Fuzzification and rule evaluation
  logic [GW-1:0] en, ez, ep, dn, dz, dp;
  logic [GW-1:0] s_nxt, m_nxt, l_nxt;
  logic [DW-1:0] den;

  always_comb begin
    {en, ez, ep} = grade3({e_r[EW-1], e_r});
    {dn, dz, dp} = grade3(d_r);
    l_nxt = gmax(gmin(en, dn), gmin(en, dz));
    s_nxt = gmax(gmin(ep, dz), gmin(ep, dp));
    m_nxt = gmax(gmax(gmin(en, dz), gmin(ez, dn)),
                 gmax(gmax(gmin(ez, dz), gmin(ez, dp)), gmin(ep, dz)));
  end

  assign den          = DW'(s_r) + DW'(m_r) + DW'(l_r);
  assign sts.den_zero = (den == '0);

  // Saturating accumulate of the error
  logic signed [SW:0]   sum_ext;
  logic signed [SW-1:0] sum_sat;

  always_comb begin
    sum_ext = {sum_r[SW-1], sum_r} + (SW + 1)'(e_r);
    if (sum_ext[SW] != sum_ext[SW-1]) begin
      sum_sat = sum_ext[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SW-1:0];
    end
  end

  // Gain and grade select for the shared MAC step
  logic [KPW-1:0]     gkp;
  logic [KIW-1:0]     gki;
  logic [GW-1:0]      gsel;
  logic [KPW+GW-1:0]  prod_kp;
  logic [KIW+GW-1:0]  prod_ki;

  always_comb begin
    case (cmd.mac_sel)
      fgs_pkg::CLS_SMALL: begin
        gkp = kps_r; gki = kis_r; gsel = s_r;
      end
      fgs_pkg::CLS_MEDIUM: begin
        gkp = kpm_r; gki = kim_r; gsel = m_r;
      end
      fgs_pkg::CLS_LARGE: begin
        gkp = kpl_r; gki = kil_r; gsel = l_r;
      end
      default: begin
        gkp = '0; gki = '0; gsel = '0;
      end
    endcase
    prod_kp = (KPW + GW)'(gkp) * (KPW + GW)'(gsel);
    prod_ki = (KIW + GW)'(gki) * (KIW + GW)'(gsel);
  end

  // Sample capture, grading and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      sum_r  <= '0;
    end else begin
      if (cmd.load) begin
        prev_r <= error_sample;
      end
      if (cmd.grade) begin
        sum_r <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_r <= error_sample;
      d_r <= {error_sample[EW-1], error_sample} - {prev_r[EW-1], prev_r};
    end
    if (cmd.grade) begin
      s_r      <= s_nxt;
      m_r      <= m_nxt;
      l_r      <= l_nxt;
      acc_kp_r <= '0;
      acc_ki_r <= '0;
    end
    if (cmd.mac) begin
      acc_kp_r <= acc_kp_r + NKP_W'(prod_kp);
      acc_ki_r <= acc_ki_r + NW'(prod_ki);
    end
  end

  // Weighted-average divider, one quotient bit per cycle for both gains
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      nkp_r <= NW'(acc_kp_r);
      nki_r <= acc_ki_r;
      rkp_r <= '0;
      rki_r <= '0;
    end else if (cmd.div_step) begin
      {rkp_r, nkp_r} <= div_iter(rkp_r, nkp_r, den);
      {rki_r, nki_r} <= div_iter(rki_r, nki_r, den);
    end
  end

  // Gains in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_held_r <= '0;
      ki_held_r <= '0;
    end else if (cmd.gain_upd) begin
      kp_held_r <= nkp_r[KPW-1:0];
      ki_held_r <= nki_r[KIW-1:0];
    end
  end

  // PI products
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pkp_r <= PKP_W'($signed({1'b0, kp_held_r})) * PKP_W'(e_r);
      pki_r <= PKI_W'($signed({1'b0, ki_held_r})) * PKI_W'(sum_r);
    end
  end

  // Sum, floor shift and clamp
  logic signed [V_W-1:0] v;
  logic signed [Q_W-1:0] vq;
  logic [fgs_pkg::DUTY_W-1:0] duty;

  always_comb begin
    v  = (V_W'(pkp_r) <<< 8) + V_W'(pki_r);
    vq = v[V_W-1:24];
    if (vq[Q_W-1]) begin
      duty = '0;
    end else if (|vq[Q_W-2:fgs_pkg::DUTY_W]) begin
      duty = fgs_pkg::DUTY_MAX;
    end else begin
      duty = vq[fgs_pkg::DUTY_W-1:0];
    end
  end

  // Output register
  logic                        out_valid_r;
  logic [fgs_pkg::DUTY_W-1:0]  pwm_r;
  logic [KPW-1:0]              kp_out_r;
  logic [KIW-1:0]              ki_out_r;

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pwm_r    <= duty;
      kp_out_r <= kp_held_r;
      ki_out_r <= ki_held_r;
    end
  end

  assign out_valid = out_valid_r;
  assign pwm_duty  = pwm_r;
  assign kp_now    = kp_out_r;
  assign ki_now    = ki_out_r;

  `FGS_ASSERT_NXT(a_kp_held_stable, !cmd.gain_upd, $stable(kp_held_r))
  `FGS_ASSERT_NXT(a_ki_held_stable, !cmd.gain_upd, $stable(ki_held_r))
  `FGS_ASSERT_NXT(a_out_pending, out_valid_r && !out_ready, out_valid_r && $stable(pwm_r))

endmodule
`default_nettype wire

>>> sv/fuzzy_gain_scheduled_pi_top.sv
// One sample at a time: a new input is accepted only after the previous result has
// been loaded into the output register. Gains are blended by the shift-subtract
// divider, NW = 22 + clog2(BAND+1) quotient bits (27 at BAND = 20), one bit per cycle
// for both gains; if all class grades are zero it is skipped and the old gains kept.
// Reset (synchronous, rst_n low): gains to their defaults, error history, sum and
// gains in use to zero, output empty.
`default_nettype none
module fuzzy_gain_scheduled_pi_top #(
  parameter int BAND = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  fgs_in_if.sink                                 in_chan,
  fgs_out_if.source                              out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [fgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fgs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int GW = $clog2(BAND + 1);
  localparam int NW = fgs_pkg::KI_W + GW + 2;

  fgs_pkg::ctl_cmd_t cmd;
  fgs_pkg::dp_sts_t  sts;
  logic              in_ready;

  assign in_chan.ready = in_ready;

  fgs_ctrl #(
    .DIV_STEPS (NW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fgs_dp #(
    .BAND (BAND),
    .GW   (GW),
    .NW   (NW)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .error_sample (in_chan.error_sample),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .pwm_duty     (out_chan.pwm_duty),
    .kp_now       (out_chan.kp_now),
    .ki_now       (out_chan.ki_now)
  );

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking bench for fuzzy_gain_scheduled_pi_top: drives error samples over the
// valid/ready channels, predicts duty and gains per sample, and checks every result.
// Depends on fgs_pkg, fgs_in_if, fgs_out_if and the RTL top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fgs_pkg::*;

  localparam int FUZZ_BAND    = 20;
  localparam int N_DIRECTED   = 22;
  localparam int N_PER_PHASE  = 330;
  localparam int N_PHASES     = 4;
  localparam int DRAIN_CYCLES = 48;       // drain time for a sample still in flight, plus margin
  localparam int END_WAIT     = 4000;
  localparam int RAMP_ITEMS   = 200;
  localparam int MAX_REPORTS  = 40;
  localparam longint CYCLE_LIMIT = 12_000_000;

  localparam int SUM_MAX = 32'sh7FFF_FFFF;
  localparam int SUM_MIN = 32'sh8000_0000;

  // Indexes past the last gain register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [KP_W-1:0]   kp;
    logic [KI_W-1:0]   ki;
  } pi_result_t;

  typedef struct {
    logic signed [ERR_W-1:0] err;
    bit                      typed;
    pi_result_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fgs_in_if  in_chan ();
  fgs_out_if out_chan ();

  fuzzy_gain_scheduled_pi_top #(
    .BAND(FUZZ_BAND)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow of the controller: gains, error history, accumulator, gains in use
  logic [KP_W-1:0] kp_gain [3] = '{KP_SMALL_RST, KP_MEDIUM_RST, KP_LARGE_RST};
  logic [KI_W-1:0] ki_gain [3] = '{KI_SMALL_RST, KI_MEDIUM_RST, KI_LARGE_RST};
  int              err_hist = 0;
  int              err_acc  = 0;
  logic [KP_W-1:0] kp_use   = '0;
  logic [KI_W-1:0] ki_use   = '0;

  pi_result_t duty_gain_q [$];

  // Typed-in expectation for the sample currently offered
  bit         row_typed = 1'b0;
  pi_result_t row_want  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int cfg_writes     = 0;
  int held_count     = 0;
  int mismatch_count = 0;
  logic signed [ERR_W-1:0] last_sent = '0;
  longint cycle_count = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{16'sd0,   1'b1, '{8'd0,    KP_MEDIUM_RST, KI_MEDIUM_RST}},
    '{16'h7FFF, 1'b1, '{DUTY_MAX, KP_SMALL_RST, KI_SMALL_RST}},
    '{16'h8000, 1'b1, '{8'd0,    KP_LARGE_RST,  KI_LARGE_RST}},
    '{16'h7FFF, 1'b0, '0},
    '{16'sd100, 1'b0, '0},   // positive error, falling fast: no class fires
    '{16'h8000, 1'b0, '0},
    '{-16'sd100, 1'b0, '0},  // negative error, rising fast: no class fires
    '{16'sd0,   1'b0, '0},
    '{16'sd5,   1'b0, '0},
    '{16'sd10,  1'b0, '0},
    '{16'sd19,  1'b0, '0},
    '{16'sd20,  1'b0, '0},
    '{16'sd21,  1'b0, '0},
    '{16'sd0,   1'b0, '0},
    '{-16'sd19, 1'b0, '0},
    '{-16'sd20, 1'b0, '0},
    '{-16'sd21, 1'b0, '0},
    '{-16'sd5,  1'b0, '0},
    '{16'sd1,   1'b0, '0},
    '{-16'sd1,  1'b0, '0},
    '{16'sd32766, 1'b0, '0},
    '{-16'sd32767, 1'b0, '0}
  };

  function automatic int min2(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Triangular memberships, each 0..BAND
  function automatic void grade3(input int x, output int n, output int z, output int p);
    n = 0;
    z = 0;
    p = 0;
    if (x <= -FUZZ_BAND) begin
      n = FUZZ_BAND;
    end else if (x >= FUZZ_BAND) begin
      p = FUZZ_BAND;
    end else if (x >= 0) begin
      p = x;
      z = FUZZ_BAND - x;
    end else begin
      n = -x;
      z = FUZZ_BAND + x;
    end
  endfunction

  // Grade-weighted average of three gains, truncating
  function automatic longint unsigned weigh(input longint unsigned g_s, input longint unsigned g_m,
                                            input longint unsigned g_l, input int w_s,
                                            input int w_m, input int w_l);
    longint unsigned num;
    longint unsigned den;
    num = g_s * longint'(w_s) + g_m * longint'(w_m) + g_l * longint'(w_l);
    den = longint'(w_s + w_m + w_l);
    return num / den;
  endfunction

  // One controller step: schedule gains, integrate, form the clamped duty
  function automatic pi_result_t pi_update(input logic signed [ERR_W-1:0] err_in);
    int e, d;
    int ne, ze, pe, nd, zd, pd;
    int w_s, w_m, w_l;
    longint total;
    longint drive;
    pi_result_t r;
    e = err_in;
    d = e - err_hist;
    grade3(e, ne, ze, pe);
    grade3(d, nd, zd, pd);
    w_l = max2(min2(ne, nd), min2(ne, zd));
    w_s = max2(min2(pe, zd), min2(pe, pd));
    w_m = max2(max2(min2(ne, zd), min2(ze, nd)),
               max2(max2(min2(ze, zd), min2(ze, pd)), min2(pe, zd)));
    if (w_s != 0 || w_m != 0 || w_l != 0) begin
      kp_use = KP_W'(weigh(kp_gain[CLS_SMALL], kp_gain[CLS_MEDIUM], kp_gain[CLS_LARGE],
                           w_s, w_m, w_l));
      ki_use = KI_W'(weigh(ki_gain[CLS_SMALL], ki_gain[CLS_MEDIUM], ki_gain[CLS_LARGE],
                           w_s, w_m, w_l));
    end else begin
      held_count++;
    end
    total = longint'(err_acc) + longint'(e);
    if (total > longint'(SUM_MAX)) total = longint'(SUM_MAX);
    if (total < longint'(SUM_MIN)) total = longint'(SUM_MIN);
    err_acc = int'(total);
    drive = longint'(kp_use) * longint'(e) * 256 + longint'(ki_use) * longint'(err_acc);
    drive = drive >>> 24;
    if (drive > 255) drive = 255;
    if (drive < 0) drive = 0;
    err_hist = e;
    r.duty = drive[DUTY_W-1:0];
    r.kp   = kp_use;
    r.ki   = ki_use;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Compare results, record samples and register writes at each transfer
  always @(posedge clk) begin
    pi_result_t want;
    pi_result_t got;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (duty_gain_q.size() == 0) begin
          report_mismatch($sformatf("result with none pending: duty %0d kp %0d ki %0d",
                                    out_chan.pwm_duty, out_chan.kp_now, out_chan.ki_now));
        end else begin
          want = duty_gain_q.pop_front();
          if (out_chan.pwm_duty !== want.duty)
            report_mismatch($sformatf("result %0d duty %0d, want %0d",
                                      checked_count, out_chan.pwm_duty, want.duty));
          if (out_chan.kp_now !== want.kp)
            report_mismatch($sformatf("result %0d kp %0d, want %0d",
                                      checked_count, out_chan.kp_now, want.kp));
          if (out_chan.ki_now !== want.ki)
            report_mismatch($sformatf("result %0d ki %0d, want %0d",
                                      checked_count, out_chan.ki_now, want.ki));
        end
        checked_count++;
      end
      if (in_chan.valid && in_chan.ready) begin
        got = pi_update(in_chan.error_sample);
        duty_gain_q.push_back(row_typed ? row_want : got);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_KP_SMALL:  kp_gain[CLS_SMALL]  = cfg_wdata[KP_W-1:0];
          CFG_KP_MEDIUM: kp_gain[CLS_MEDIUM] = cfg_wdata[KP_W-1:0];
          CFG_KP_LARGE:  kp_gain[CLS_LARGE]  = cfg_wdata[KP_W-1:0];
          CFG_KI_SMALL:  ki_gain[CLS_SMALL]  = cfg_wdata[KI_W-1:0];
          CFG_KI_MEDIUM: ki_gain[CLS_MEDIUM] = cfg_wdata[KI_W-1:0];
          CFG_KI_LARGE:  ki_gain[CLS_LARGE]  = cfg_wdata[KI_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_chan.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL fuzzy_gain_scheduled_pi_top");
      $finish;
    end
  end

  // Offer one sample, hold it until the transfer, return on the next falling edge
  task automatic send_sample(input logic signed [ERR_W-1:0] err_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid        = 1'b1;
    in_chan.error_sample = err_in;
    do @(posedge clk); while (!in_chan.ready);
    sent_count++;
    last_sent = err_in;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    cfg_writes++;
    @(negedge clk);
  endtask

  // Drop valid and wait for the pipeline to empty
  task automatic settle();
    in_chan.valid = 1'b0;
    while (duty_gain_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly in-band and slowly moving errors, plus extremes and full-range noise
  function automatic logic signed [ERR_W-1:0] pick_sample(input int last);
    int sel;
    int t;
    sel = $urandom_range(99);
    if (sel < 35) begin
      t = int'($urandom_range(2 * FUZZ_BAND + 4)) - (FUZZ_BAND + 2);
    end else if (sel < 60) begin
      t = last + int'($urandom_range(2 * FUZZ_BAND + 4)) - (FUZZ_BAND + 2);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
    end else if (sel < 70) begin
      case ($urandom_range(5))
        0: t = -32768;
        1: t = 32767;
        2: t = -FUZZ_BAND;
        3: t = FUZZ_BAND;
        4: t = 0;
        default: t = ($urandom_range(1)) ? 32766 : -32767;
      endcase
    end else begin
      t = int'($urandom());
    end
    return ERR_W'(t);
  endfunction

  initial begin
    int ph;
    int i;
    int ramp_items;
    int waited;
    in_chan.valid        = 1'b0;
    in_chan.error_sample = '0;
    out_chan.ready       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    ramp_items = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed rows at reset gains
    for (i = 0; i < N_DIRECTED; i++) begin
      row_typed = directed_rows[i].typed;
      row_want  = directed_rows[i].want;
      send_sample(directed_rows[i].err);
    end
    row_typed = 1'b0;

    // Random phases, each with its own gain set and idling pattern
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          // all-ones data: upper bits must be dropped on the Kp registers
          write_reg(CFG_KP_SMALL,  '1);
          write_reg(CFG_KP_MEDIUM, '1);
          write_reg(CFG_KP_LARGE,  '1);
          write_reg(CFG_KI_SMALL,  '1);
          write_reg(CFG_KI_MEDIUM, '1);
          write_reg(CFG_KI_LARGE,  '1);
          write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom()));
          write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom()));
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_reg(CFG_KP_SMALL,  '0);
          write_reg(CFG_KP_MEDIUM, '0);
          write_reg(CFG_KP_LARGE,  '0);
          write_reg(CFG_KI_SMALL,  '0);
          write_reg(CFG_KI_MEDIUM, '0);
          write_reg(CFG_KI_LARGE,  '0);
          send_idle_pct  = 48;
          recv_stall_pct = 0;
        end
        default: begin
          write_reg(CFG_KP_SMALL,  CFG_DATA_W'($urandom()));
          write_reg(CFG_KP_MEDIUM, CFG_DATA_W'($urandom()));
          write_reg(CFG_KP_LARGE,  CFG_DATA_W'($urandom()));
          write_reg(CFG_KI_SMALL,  CFG_DATA_W'($urandom()));
          write_reg(CFG_KI_MEDIUM, CFG_DATA_W'($urandom()));
          write_reg(CFG_KI_LARGE,  CFG_DATA_W'($urandom()));
          write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom()));
          send_idle_pct  = (ph == 2) ? 0 : 20;
          recv_stall_pct = (ph == 2) ? 48 : 20;
        end
      endcase
      cfg_we = 1'b0;
      for (i = 0; i < N_PER_PHASE; i++) send_sample(pick_sample(last_sent));
    end

    // Integral-only gains: ramp the sum up with full-scale error, then pull it below zero
    settle();
    write_reg(CFG_KP_SMALL,  '0);
    write_reg(CFG_KP_MEDIUM, '0);
    write_reg(CFG_KP_LARGE,  '0);
    write_reg(CFG_KI_SMALL,  '1);
    write_reg(CFG_KI_MEDIUM, '1);
    write_reg(CFG_KI_LARGE,  '1);
    cfg_we = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (RAMP_ITEMS) begin
      send_sample(16'h7FFF);
      ramp_items++;
    end
    repeat (RAMP_ITEMS + 2) begin
      send_sample(16'h8000);
      ramp_items++;
    end
    in_chan.valid = 1'b0;

    // Drain, then give late or extra results time to show up
    waited = 0;
    while (duty_gain_q.size() != 0 && waited < END_WAIT) begin
      @(negedge clk);
      waited++;
    end
    if (duty_gain_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", duty_gain_q.size()));
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d samples (%0d directed, %0d with integral-only gains), %0d results",
             sent_count, N_DIRECTED, ramp_items, checked_count);
    $display("with %0d gain writes, %0d steps keeping old gains, %0d mismatches",
             cfg_writes, held_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS fuzzy_gain_scheduled_pi_top");
    end else begin
      $display("FAIL fuzzy_gain_scheduled_pi_top");
    end
    $finish;
  end

endmodule

>>> fuzzy_gain_scheduled_pi_top.f
+incdir+sv
sv/fgs_pkg.sv
sv/fgs_in_if.sv
sv/fgs_out_if.sv
sv/fgs_ctrl.sv
sv/fgs_dp.sv
sv/fuzzy_gain_scheduled_pi_top.sv
verif/testbench.sv
